// ----- src/pbwp_pkg.sv -----
// Package for the protobuf wire-format parser.
// Holds parse phase, event and error codes, and the event record.
// No dependencies; used by pbwp_core and protobuf_wire_parser.
package pbwp_pkg;

    // Parse phase between input items
    typedef enum logic [2:0] {
        PH_TAG     = 3'd0,
        PH_VALUE   = 3'd1,
        PH_LEN     = 3'd2,
        PH_PAYLOAD = 3'd3,
        PH_FIXED   = 3'd4
    } t_phase;

    // Event kinds on the result channel
    localparam logic [2:0] EV_TAG     = 3'd0;
    localparam logic [2:0] EV_VALUE   = 3'd1;
    localparam logic [2:0] EV_LEN     = 3'd2;
    localparam logic [2:0] EV_PAYLOAD = 3'd3;
    localparam logic [2:0] EV_FIXED   = 3'd4;
    localparam logic [2:0] EV_END     = 3'd5;
    localparam logic [2:0] EV_ERROR   = 3'd6;

    // Error codes
    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_TRUNC     = 2'd1;
    localparam logic [1:0] ERR_VARINT    = 2'd2;
    localparam logic [1:0] ERR_BAD_WIRE  = 2'd3;

    // Wire types
    localparam logic [2:0] WT_VARINT = 3'd0;
    localparam logic [2:0] WT_FIX64  = 3'd1;
    localparam logic [2:0] WT_LEN    = 3'd2;
    localparam logic [2:0] WT_FIX32  = 3'd5;

    // Varint limits and fixed skip lengths
    localparam int unsigned VARINT_MAX_BYTES = 10;
    localparam logic [3:0]  VARINT_LAST_IDX  = 4'd9;
    localparam logic [63:0] FIX64_BYTES      = 64'd8;
    localparam logic [63:0] FIX32_BYTES      = 64'd4;

    // One result item
    typedef struct packed {
        logic [2:0]  event_kind;
        logic [31:0] field_number;
        logic [2:0]  wire_kind;
        logic [63:0] decoded_value;
        logic [7:0]  payload_byte;
        logic        buffer_done;
        logic [1:0]  error_code;
    } t_event;

endpackage

// ----- src/pbwp_core.sv -----
// Parser state and one-byte step logic of the protobuf wire-format parser.
// Holds the parse state registers and computes the event of each byte.
// Depends on pbwp_pkg.
module pbwp_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_adv,
    input  logic [7:0]           i_byte,
    input  logic                 i_final,
    output logic                 o_have,
    output pbwp_pkg::t_event     o_evt
);

    pbwp_pkg::t_phase r_phase, n_phase;
    logic [63:0]      r_acc, n_acc;
    logic [3:0]       r_seen, n_seen;
    logic [63:0]      r_rem, n_rem;
    logic [31:0]      r_field, n_field;
    logic [2:0]       r_wire, n_wire;
    logic             r_err, n_err;

    logic [3:0]       seen_c;
    logic [63:0]      slot;
    logic [63:0]      acc;
    logic [1:0]       code;
    logic             do_reset;

    // Place the 7 data bits of this byte at its varint slot
    always_comb begin
        seen_c = (r_seen > pbwp_pkg::VARINT_LAST_IDX) ? pbwp_pkg::VARINT_LAST_IDX : r_seen;
        slot   = '0;
        for (int k = 0; k < pbwp_pkg::VARINT_MAX_BYTES; k++) begin
            if (seen_c == 4'(k)) begin
                slot = 64'(i_byte[6:0]) << (7 * k);
            end
        end
        acc = r_acc | slot;
    end

    // Step the parser by one byte
    always_comb begin
        n_phase  = r_phase;
        n_acc    = r_acc;
        n_seen   = r_seen;
        n_rem    = r_rem;
        n_field  = r_field;
        n_wire   = r_wire;
        n_err    = r_err;
        code     = pbwp_pkg::ERR_NONE;
        do_reset = 1'b0;
        o_have   = 1'b0;
        o_evt    = '0;

        if (r_err) begin
            // Drop bytes until the final byte, which ends the buffer
            if (i_final) begin
                o_have           = 1'b1;
                o_evt.event_kind = pbwp_pkg::EV_END;
                do_reset         = 1'b1;
            end
        end else begin
            case (r_phase)
                pbwp_pkg::PH_PAYLOAD: begin
                    o_have             = 1'b1;
                    o_evt.event_kind   = pbwp_pkg::EV_PAYLOAD;
                    o_evt.payload_byte = i_byte;
                    if (r_rem[63:1] == '0) begin
                        n_rem   = '0;
                        n_phase = pbwp_pkg::PH_TAG;
                    end else begin
                        n_rem = r_rem - 64'd1;
                    end
                end
                pbwp_pkg::PH_FIXED: begin
                    if (r_rem[63:1] == '0) begin
                        n_rem            = '0;
                        n_phase          = pbwp_pkg::PH_TAG;
                        o_have           = 1'b1;
                        o_evt.event_kind = pbwp_pkg::EV_FIXED;
                    end else begin
                        n_rem = r_rem - 64'd1;
                    end
                end
                default: begin
                    // Varint byte of a tag, value or length
                    n_seen = seen_c + 4'd1;
                    if (i_byte[7]) begin
                        n_acc = acc;
                        if (seen_c == pbwp_pkg::VARINT_LAST_IDX) begin
                            code = pbwp_pkg::ERR_VARINT;
                        end else if (i_final) begin
                            code = pbwp_pkg::ERR_TRUNC;
                        end
                    end else begin
                        n_acc  = '0;
                        n_seen = '0;
                        if (r_phase == pbwp_pkg::PH_VALUE) begin
                            o_have              = 1'b1;
                            o_evt.event_kind    = pbwp_pkg::EV_VALUE;
                            o_evt.decoded_value = acc;
                            n_phase             = pbwp_pkg::PH_TAG;
                        end else if (r_phase == pbwp_pkg::PH_LEN) begin
                            o_have              = 1'b1;
                            o_evt.event_kind    = pbwp_pkg::EV_LEN;
                            o_evt.decoded_value = acc;
                            if (acc == '0) begin
                                n_phase = pbwp_pkg::PH_TAG;
                            end else begin
                                n_rem   = acc;
                                n_phase = pbwp_pkg::PH_PAYLOAD;
                            end
                        end else begin
                            // Tag: split into field number and wire type
                            n_field = acc[34:3];
                            n_wire  = acc[2:0];
                            case (acc[2:0])
                                pbwp_pkg::WT_VARINT: n_phase = pbwp_pkg::PH_VALUE;
                                pbwp_pkg::WT_LEN:    n_phase = pbwp_pkg::PH_LEN;
                                pbwp_pkg::WT_FIX64: begin
                                    n_phase = pbwp_pkg::PH_FIXED;
                                    n_rem   = pbwp_pkg::FIX64_BYTES;
                                end
                                pbwp_pkg::WT_FIX32: begin
                                    n_phase = pbwp_pkg::PH_FIXED;
                                    n_rem   = pbwp_pkg::FIX32_BYTES;
                                end
                                default: begin
                                    n_phase = pbwp_pkg::PH_TAG;
                                    code    = pbwp_pkg::ERR_BAD_WIRE;
                                end
                            endcase
                            if (code == pbwp_pkg::ERR_NONE) begin
                                o_have           = 1'b1;
                                o_evt.event_kind = pbwp_pkg::EV_TAG;
                            end
                        end
                    end
                end
            endcase

            // Final byte: clean end or truncation
            if (code == pbwp_pkg::ERR_NONE && i_final) begin
                if (o_have && n_phase == pbwp_pkg::PH_TAG) begin
                    o_evt.buffer_done = 1'b1;
                    do_reset          = 1'b1;
                end else begin
                    code = pbwp_pkg::ERR_TRUNC;
                end
            end
            if (code != pbwp_pkg::ERR_NONE) begin
                o_have        = 1'b1;
                o_evt         = '0;
                o_evt.event_kind = pbwp_pkg::EV_ERROR;
                o_evt.error_code = code;
                if (i_final) begin
                    do_reset = 1'b1;
                end else begin
                    n_err = 1'b1;
                end
            end
        end

        // Every event reports the element as it stands after this byte
        o_evt.field_number = n_field;
        o_evt.wire_kind    = n_wire;

        if (do_reset) begin
            n_phase = pbwp_pkg::PH_TAG;
            n_acc   = '0;
            n_seen  = '0;
            n_rem   = '0;
            n_field = '0;
            n_wire  = '0;
            n_err   = 1'b0;
        end
    end

    // Parser state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= pbwp_pkg::PH_TAG;
            r_acc   <= '0;
            r_seen  <= '0;
            r_rem   <= '0;
            r_field <= '0;
            r_wire  <= '0;
            r_err   <= 1'b0;
        end else if (i_adv) begin
            r_phase <= n_phase;
            r_acc   <= n_acc;
            r_seen  <= n_seen;
            r_rem   <= n_rem;
            r_field <= n_field;
            r_wire  <= n_wire;
            r_err   <= n_err;
        end
    end

    // A latched error only arises in a varint phase, never in payload or fixed
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_err |-> (r_phase != pbwp_pkg::PH_PAYLOAD && r_phase != pbwp_pkg::PH_FIXED))
        else $error("pbwp_core: latched error state");

    // Varint byte count never passes the limit
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seen <= 4'(pbwp_pkg::VARINT_MAX_BYTES))
        else $error("pbwp_core: varint byte count overflow");

    // A payload or fixed phase always has bytes left
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_err && (r_phase == pbwp_pkg::PH_PAYLOAD || r_phase == pbwp_pkg::PH_FIXED))
        |-> r_rem != '0)
        else $error("pbwp_core: empty skip count in payload or fixed phase");

endmodule

// ----- src/protobuf_wire_parser.sv -----
// Top level of the protobuf wire-format parser.
// Input register, parser step (pbwp_core) and result register.
// Depends on pbwp_pkg and pbwp_core.
//
//  channel  | handshake          | payload
//  ---------+--------------------+------------------------------------------
//  input    | i_valid / o_stall  | i_in_byte, i_final_byte
//  result   | o_valid / i_stall  | o_event_kind ... o_error_code (7 fields)
//
// One byte is taken every cycle while o_stall is low; its result goes from the
// input register through the parser step into the result register.
// Bytes that give no event leave no result item.
// A stalled result holds in the result register while the next byte waits
// in the input register; o_stall rises only when both are occupied.
// Reset clears the valid flags and the parser state; payload is not reset.
module protobuf_wire_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_in_byte,
    input  logic        i_final_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_event_kind,
    output logic [31:0] o_field_number,
    output logic [2:0]  o_wire_kind,
    output logic [63:0] o_decoded_value,
    output logic [7:0]  o_payload_byte,
    output logic        o_buffer_done,
    output logic [1:0]  o_error_code
);

    logic             r_in_valid;
    logic [7:0]       r_in_byte;
    logic             r_in_final;
    logic             r_out_valid;
    pbwp_pkg::t_event r_out;

    logic             adv;
    logic             in_take;
    logic             have;
    pbwp_pkg::t_event evt;

    // Advance the held byte when the result register is free or draining
    assign adv     = r_in_valid && (!r_out_valid || !i_stall);
    assign o_stall = r_in_valid && !adv;
    assign in_take = i_valid && !o_stall;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_byte  <= i_in_byte;
            r_in_final <= i_final_byte;
        end
    end

    pbwp_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_byte  (r_in_byte),
        .i_final (r_in_final),
        .o_have  (have),
        .o_evt   (evt)
    );

    // Result register: load on an event, drop once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv && have) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && have) begin
            r_out <= evt;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_event_kind    = r_out.event_kind;
    assign o_field_number  = r_out.field_number;
    assign o_wire_kind     = r_out.wire_kind;
    assign o_decoded_value = r_out.decoded_value;
    assign o_payload_byte  = r_out.payload_byte;
    assign o_buffer_done   = r_out.buffer_done;
    assign o_error_code    = r_out.error_code;

    // Upstream is held only while a byte waits behind a stalled result
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> r_in_valid && r_out_valid && i_stall)
        else $error("protobuf_wire_parser: stall without a blocked result");

    // An error event always carries a code, other events none
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_event_kind == pbwp_pkg::EV_ERROR) ==
                     (o_error_code != pbwp_pkg::ERR_NONE)))
        else $error("protobuf_wire_parser: error code mismatch");

    // A clean end is never reported on an error or end-only event
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_buffer_done) |->
            (o_event_kind != pbwp_pkg::EV_ERROR && o_event_kind != pbwp_pkg::EV_END))
        else $error("protobuf_wire_parser: buffer done on error or end event");

    // Only value and length events carry a decoded value
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_event_kind != pbwp_pkg::EV_VALUE && o_event_kind != pbwp_pkg::EV_LEN)
        |-> o_decoded_value == '0)
        else $error("protobuf_wire_parser: stray decoded value");

endmodule
